>>> rtl/hetk_pkg.sv
// Shared constants and types for the hard-example top-k selector.
// No dependencies; every other file imports this package.
`default_nettype none
package hetk_pkg;
    localparam int MAX_ROIS    = 64;
    localparam int ROI_W       = 6;
    localparam int CNT_W       = 7;
    localparam int IMG_W       = 4;
    localparam int LOSS_W      = 32;
    localparam int LABEL_W     = 10;
    localparam int LOUT_W      = 11;
    localparam int QUOTA_W     = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUOTA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE = 1'b1;

    typedef struct packed {
        logic [IMG_W-1:0]   image_index;
        logic [LOSS_W-1:0]  loss;
        logic [LABEL_W-1:0] label;
        logic               last_in;
    } t_item;

    typedef struct packed {
        logic [QUOTA_W-1:0]       quota;
        logic signed [LOUT_W-1:0] ignore_value;
    } t_cfg;
endpackage
`default_nettype wire

>>> rtl/hetk_if.sv
// Valid/ready channel interfaces for region input and result output.
// Depends on hetk_pkg for field widths.
`default_nettype none
interface hetk_in_if import hetk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IMG_W-1:0]   image_index;
    logic [LOSS_W-1:0]  loss;
    logic [LABEL_W-1:0] label;
    logic               last_in;
    modport source (output valid, image_index, loss, label, last_in, input ready);
    modport sink (input valid, image_index, loss, label, last_in, output ready);
endinterface

interface hetk_out_if import hetk_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ROI_W-1:0]         region_index;
    logic                     keep;
    logic signed [LOUT_W-1:0] label_out;
    logic                     last_out;
    modport source (output valid, region_index, keep, label_out, last_out, input ready);
    modport sink (input valid, region_index, keep, label_out, last_out, output ready);
endinterface
`default_nettype wire

>>> rtl/hetk_front.sv
// Front end: accepts region transactions into a short queue for the back end.
// Depends on hetk_pkg and hetk_in_if.
`default_nettype none
module hetk_front import hetk_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    hetk_in_if.sink i_roi,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  wire   i_q_pop
);
    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               push;

    assign i_roi.ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push        = i_roi.valid && i_roi.ready;
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_item    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{image_index: i_roi.image_index, loss: i_roi.loss,
                             label: i_roi.label, last_in: i_roi.last_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(i_q_pop);
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("queue popped while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overflow");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");
`endif
endmodule
`default_nettype wire

>>> rtl/hetk_back.sv
// Back end: region store, per-region rank count against its image, result output.
// Depends on hetk_pkg and hetk_out_if.
`default_nettype none
module hetk_back import hetk_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_cfg  i_cfg,
    input  wire   i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_pop,
    hetk_out_if.source o_res
);
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_HOLD  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam int WORD_W = IMG_W + LOSS_W + LABEL_W;

    logic [WORD_W-1:0]  r_store [MAX_ROIS];
    logic [WORD_W-1:0]  r_rd;
    logic [ROI_W-1:0]   rd_addr;
    logic [2:0]         r_st;
    logic [CNT_W-1:0]   r_cnt, r_i, r_rank;
    logic [ROI_W-1:0]   r_j, r_pidx;
    logic               r_pv;
    logic [IMG_W-1:0]   r_jimg, rd_img;
    logic [LOSS_W-1:0]  r_jloss, rd_loss;
    logic [LABEL_W-1:0] r_jlabel, rd_label;
    logic               ahead, wr_en, keep;

    assign {rd_img, rd_loss, rd_label} = r_rd;
    assign o_q_pop = (r_st == S_LOAD) && i_q_valid;
    assign wr_en   = o_q_pop && (r_cnt != CNT_W'(MAX_ROIS));
    assign ahead   = r_pv && (rd_img == r_jimg) &&
                     ((rd_loss > r_jloss) || ((rd_loss == r_jloss) && (r_pidx < r_j)));
    assign keep    = r_rank < i_cfg.quota;

    always_comb begin
        unique case (r_st)
            S_FETCH: rd_addr = r_j;
            S_HOLD:  rd_addr = '0;
            default: rd_addr = r_i[ROI_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_store[r_cnt[ROI_W-1:0]] <= {i_q_item.image_index, i_q_item.loss,
                                                i_q_item.label};
        r_rd <= r_store[rd_addr];
    end

    assign o_res.valid        = (r_st == S_EMIT);
    assign o_res.region_index = r_j;
    assign o_res.keep         = keep;
    assign o_res.label_out    = keep ? $signed({1'b0, r_jlabel}) : i_cfg.ignore_value;
    assign o_res.last_out     = (CNT_W'(r_j) + 1'b1 == r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_LOAD;
            r_cnt <= '0;
            r_j   <= '0;
            r_i   <= '0;
            r_pv  <= 1'b0;
        end else begin
            unique case (r_st)
                S_LOAD: begin
                    if (o_q_pop) begin
                        if (wr_en) r_cnt <= r_cnt + 1'b1;
                        if (i_q_item.last_in) begin
                            r_j  <= '0;
                            r_st <= S_FETCH;
                        end
                    end
                end
                S_FETCH: r_st <= S_HOLD;
                S_HOLD: begin
                    r_jimg   <= rd_img;
                    r_jloss  <= rd_loss;
                    r_jlabel <= rd_label;
                    r_rank   <= '0;
                    r_pv     <= 1'b1;
                    r_pidx   <= '0;
                    r_i      <= CNT_W'(1);
                    r_st     <= S_SCAN;
                end
                S_SCAN: begin
                    if (ahead) r_rank <= r_rank + 1'b1;
                    r_pv   <= (r_i < r_cnt);
                    r_pidx <= r_i[ROI_W-1:0];
                    if (r_i < r_cnt) r_i <= r_i + 1'b1;
                    if (!r_pv) r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_res.ready) begin
                        if (o_res.last_out) begin
                            r_cnt <= '0;
                            r_st  <= S_LOAD;
                        end else begin
                            r_j  <= r_j + 1'b1;
                            r_st <= S_FETCH;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTH
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ROIS)) else $error("store count overflow");
    a_emit_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (CNT_W'(r_j) < r_cnt)) else $error("result beyond set");
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_rank < r_cnt)) else $error("rank exceeds set size");
`endif
endmodule
`default_nettype wire

>>> rtl/hard_example_top_k_per_image.sv
// Top level of the hard-example top-k selector: configuration registers,
// front queue and back end. Depends on hetk_pkg, hetk_if, hetk_front, hetk_back.
//
// Regions load at one transaction per cycle, while the queue is not full, into a
// four-entry queue and a 64-entry store. After the closing region, each loaded
// region j is ranked by a scan of the whole store through its single read port,
// and result j leaves once that scan is done and the receiver is ready. Input is
// not taken into the store while results are being produced; the queue absorbs
// the first four regions of the next set.
`default_nettype none
module hard_example_top_k_per_image import hetk_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    hetk_in_if.sink                i_roi,
    hetk_out_if.source             o_res
);
    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quota        <= QUOTA_W'(64);
            r_cfg.ignore_value <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUOTA:  r_cfg.quota <= i_cfg_data[QUOTA_W-1:0];
                CFG_IGNORE: r_cfg.ignore_value <= $signed(i_cfg_data[LOUT_W-1:0]);
                default: ;
            endcase
        end
    end

    hetk_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_roi     (i_roi),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    hetk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire

>>> sim/tb_hard_example_top_k_per_image.sv
// Self-checking testbench for hard_example_top_k_per_image: drives region sets
// over hetk_in_if and checks every result on hetk_out_if against a built-in predictor.
// Depends on hetk_pkg, hetk_if and the RTL of the block.
`default_nettype none
module tb_hard_example_top_k_per_image;
    timeunit 1ns;
    timeprecision 1ps;
    import hetk_pkg::*;

    localparam int NUM_IMAGES  = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        t_item item;
        int    gap;
        bit    drain;
    } t_region_req;

    typedef struct {
        logic [ROI_W-1:0]         region_index;
        logic                     keep;
        logic signed [LOUT_W-1:0] label_out;
        logic                     last_out;
    } t_selection;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hetk_in_if  roi_if ();
    hetk_out_if res_if ();

    hard_example_top_k_per_image dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_roi      (roi_if),
        .o_res      (res_if)
    );

    t_region_req region_queue[$];
    t_selection  selections_due[$];

    logic [QUOTA_W-1:0]       quota_setting;
    logic signed [LOUT_W-1:0] ignore_setting;

    logic [LOSS_W-1:0]  set_loss [MAX_ROIS];
    logic [IMG_W-1:0]   set_image [MAX_ROIS];
    logic [LABEL_W-1:0] set_label [MAX_ROIS];
    int                 set_count;

    t_item on_bus;
    int    gap_count;
    int    gap_max;
    int    stall_max;
    int    stall_left;
    int    hold_left;
    bit    hold_arm;
    bit    hold_done;
    int    mismatches;
    int    cycles;
    int    regions_queued;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Ranks the closed set by loss, lower load position first on ties, and
    // grants each image up to its quota of the highest-loss regions.
    function automatic void rank_and_select();
        bit          visited [MAX_ROIS];
        bit          kept [MAX_ROIS];
        int          quota_left [NUM_IMAGES];
        int          best;
        t_selection  sel;
        for (int i = 0; i < NUM_IMAGES; i++) quota_left[i] = quota_setting;
        for (int i = 0; i < MAX_ROIS; i++) begin
            visited[i] = 0;
            kept[i] = 0;
        end
        for (int r = 0; r < set_count; r++) begin
            best = -1;
            for (int i = 0; i < set_count; i++) begin
                if (!visited[i] && (best < 0 || set_loss[i] > set_loss[best])) best = i;
            end
            visited[best] = 1;
            if (quota_left[set_image[best]] > 0) begin
                quota_left[set_image[best]]--;
                kept[best] = 1;
            end
        end
        for (int i = 0; i < set_count; i++) begin
            sel.region_index = i[ROI_W-1:0];
            sel.keep = kept[i];
            sel.label_out = kept[i] ? $signed({1'b0, set_label[i]}) : ignore_setting;
            sel.last_out = (i == set_count - 1);
            selections_due.push_back(sel);
        end
        set_count = 0;
    endfunction

    function automatic void record_region(t_item it);
        if (set_count < MAX_ROIS) begin
            set_loss[set_count] = it.loss;
            set_image[set_count] = it.image_index;
            set_label[set_count] = it.label;
            set_count++;
        end
        if (it.last_in) rank_and_select();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            roi_if.valid <= 1'b0;
            gap_count = 0;
            set_count = 0;
        end else begin
            if (roi_if.valid && roi_if.ready) record_region(on_bus);
            if (!roi_if.valid || roi_if.ready) begin
                if (region_queue.size() > 0 && gap_count < region_queue[0].gap) begin
                    gap_count++;
                    roi_if.valid <= 1'b0;
                end else if (region_queue.size() > 0 &&
                             !(region_queue[0].drain && selections_due.size() > 0)) begin
                    on_bus = region_queue.pop_front().item;
                    gap_count = 0;
                    roi_if.valid       <= 1'b1;
                    roi_if.image_index <= on_bus.image_index;
                    roi_if.loss        <= on_bus.loss;
                    roi_if.label       <= on_bus.label;
                    roi_if.last_in     <= on_bus.last_in;
                end else begin
                    roi_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_selection want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (selections_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: region %0d keep %0d label %0d last %0d",
                                 res_if.region_index, res_if.keep, res_if.label_out,
                                 res_if.last_out);
                end else begin
                    want = selections_due.pop_front();
                    if (res_if.region_index !== want.region_index || res_if.keep !== want.keep
                        || res_if.label_out !== want.label_out
                        || res_if.last_out !== want.last_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected region %0d keep %0d label %0d ",
                                      "last %0d, got region %0d keep %0d label %0d last %0d"},
                                     want.region_index, want.keep, want.label_out,
                                     want.last_out, res_if.region_index, res_if.keep,
                                     res_if.label_out, res_if.last_out);
                    end
                end
                stall_left = $urandom_range(0, stall_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            res_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_hard_example_top_k_per_image: errors");
            $finish;
        end
    end

    task automatic add_region(int img, logic [LOSS_W-1:0] loss, int label, bit last,
                              bit drain = 0);
        t_region_req req;
        req.item.image_index = img[IMG_W-1:0];
        req.item.loss = loss;
        req.item.label = label[LABEL_W-1:0];
        req.item.last_in = last;
        req.gap = $urandom_range(0, gap_max);
        req.drain = drain;
        region_queue.push_back(req);
        regions_queued++;
    endtask

    function automatic logic [LOSS_W-1:0] pick_loss();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom & 32'hFFFF_0000;
        endcase
    endfunction

    task automatic add_random_set(int size, int img_max);
        for (int i = 0; i < size; i++)
            add_region($urandom_range(0, img_max), pick_loss(), $urandom_range(0, 1023),
                       i == size - 1);
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (region_queue.size() > 0 || roi_if.valid || selections_due.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_QUOTA) quota_setting = data[QUOTA_W-1:0];
        else ignore_setting = $signed(data);
    endtask

    initial begin
        int size;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_QUOTA;
        i_cfg_data = '0;
        roi_if.valid = 1'b0;
        roi_if.image_index = '0;
        roi_if.loss = '0;
        roi_if.label = '0;
        roi_if.last_in = 1'b0;
        res_if.ready = 1'b0;
        quota_setting = 7'd64;
        ignore_setting = -11'sd1;
        gap_max = 0;
        stall_max = 0;
        hold_arm = 1'b0;
        mismatches = 0;
        cycles = 0;
        regions_queued = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single region, extreme fields, equal losses.
        add_region(0, 32'h0, 0, 1);
        add_region(15, 32'hFFFF_FFFF, 1023, 0);
        add_region(15, 32'hFFFF_FFFF, 0, 0);
        add_region(0, 32'h0001_0000, 1023, 0);
        add_region(10, 32'h5555_AAAA, 682, 0);
        add_region(5, 32'hAAAA_5555, 341, 1);
        wait_quiet();
        write_reg(CFG_QUOTA, 11'd1);
        write_reg(CFG_IGNORE, 11'd1023);
        gap_max = 4;
        stall_max = 4;
        for (int i = 0; i < 8; i++) add_region(i % 2, 32'd7, 100 + i, i == 7);
        wait_quiet();
        write_reg(CFG_QUOTA, 11'd0);
        write_reg(CFG_IGNORE, 11'h400);
        for (int i = 0; i < 3; i++) add_region(i, 32'hFFFF_FFFF, 5, i == 2);
        wait_quiet();

        // Store overflow: the closing region is dropped but still ends the set.
        write_reg(CFG_QUOTA, 11'd127);
        write_reg(CFG_IGNORE, 11'd0);
        gap_max = 0;
        stall_max = 0;
        for (int i = 0; i < 66; i++) add_region(i % 16, pick_loss(), i, i == 65);
        wait_quiet();
        write_reg(CFG_QUOTA, 11'd64);
        for (int i = 0; i < 64; i++) add_region(i % 3, pick_loss(), 1023 - i, i == 63);
        wait_quiet();

        // Long receiver hold while the sender keeps offering short sets.
        write_reg(CFG_QUOTA, 11'd2);
        write_reg(CFG_IGNORE, 11'h7FF);
        hold_arm <= 1'b1;
        for (int s = 0; s < 12; s++) add_random_set(3, 1);
        wait_quiet();

        // Random phases under changing settings.
        while (regions_queued < 410) begin
            case ($urandom_range(0, 5))
                0: write_reg(CFG_QUOTA, 11'd0);
                1: write_reg(CFG_QUOTA, 11'd127);
                2: write_reg(CFG_QUOTA, 11'd64);
                default: write_reg(CFG_QUOTA, CFG_DATA_W'($urandom_range(1, 4)));
            endcase
            write_reg(CFG_IGNORE, CFG_DATA_W'($urandom_range(0, 2047)));
            gap_max = $urandom_range(0, 1) ? 4 : 0;
            stall_max = $urandom_range(0, 1) ? 4 : 0;
            for (int s = 0; s < 6; s++) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
                add_random_set(size, $urandom_range(0, 1) ? 15 : 3);
            end
            add_region($urandom_range(0, 15), pick_loss(), $urandom_range(0, 1023), 1, 1);
            wait_quiet();
        end

        wait_quiet();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_hard_example_top_k_per_image: clean");
        end else begin
            $display("tb_hard_example_top_k_per_image: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
